[rtl/websocket_frame_deframer_assert.svh]
// Assertion macros for the WebSocket deframer.
// Each macro takes a label, the clock, the reset, a condition, a consequence and a message.
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define WSFD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequence must hold in the cycle after the condition.
`define WSFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/wsfd_pkg.sv]
`timescale 1ns / 1ps

package wsfd_pkg;

  // Default width of the payload length counter.
  localparam int LENGTH_BITS_DEF = 64;

  // Header constants.
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES = 4'd4;

  // Opcodes used by the parser; close and pong touch the closed flag.
  localparam logic [3:0] OP_CONT = 4'h0;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PONG = 4'hA;

  // Parse phases.
  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4
  } wsfd_phase_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic [3:0] message_opcode;
    logic       frame_end;
    logic       message_end;
    logic       peer_closed;
  } wsfd_result_t;

endpackage

[rtl/wsfd_parser.sv]
`timescale 1ns / 1ps

module wsfd_parser #(
  parameter int LENGTH_BITS = wsfd_pkg::LENGTH_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            rx_byte,
  output logic                  res_valid,
  output wsfd_pkg::wsfd_result_t res
);
  import wsfd_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LEN_ONE = {{(LENGTH_BITS-1){1'b0}}, 1'b1};

  wsfd_phase_t            phase, phase_next;
  logic [3:0]             ext_count, ext_count_next;
  logic                   frame_final, frame_final_next;
  logic [3:0]             frame_opcode, frame_opcode_next;
  logic [3:0]             msg_opcode, msg_opcode_next;
  logic                   frame_masked, frame_masked_next;
  logic [LENGTH_BITS-1:0] remaining, remaining_next;
  logic [31:0]            mask_key, mask_key_next;
  logic [1:0]             mask_index, mask_index_next;
  logic                   closed_flag, closed_flag_next;

  logic [6:0]             len7;
  logic                   len_ext;
  logic [LENGTH_BITS-1:0] rem_ext;
  logic                   count_done;
  logic                   emit;
  logic                   emit_last;
  logic                   emit_valid;
  logic [7:0]             emit_data;
  logic [7:0]             key_byte;

  assign len7 = rx_byte[6:0];
  assign len_ext = (len7 == LEN_EXT16) || (len7 == LEN_EXT64);
  assign count_done = (ext_count == 4'd1);

  // Shift an extended length byte in, saturating when the counter would overflow.
  always_comb begin
    if (remaining[LENGTH_BITS-1 -: 8] != 8'd0) begin
      rem_ext = '1;
    end else begin
      rem_ext = {remaining[LENGTH_BITS-9:0], rx_byte};
    end
  end

  // Key byte for the current payload position, first key byte first.
  always_comb begin
    unique case (mask_index)
      2'd0: key_byte = mask_key[31:24];
      2'd1: key_byte = mask_key[23:16];
      2'd2: key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  // Next parse phase.
  always_comb begin
    phase_next = phase;
    if (step) begin
      unique case (phase)
        PH_HDR1: begin
          if (len_ext) begin
            phase_next = PH_EXT;
          end else if (rx_byte[7]) begin
            phase_next = PH_KEY;
          end else if (len7 == 7'd0) begin
            phase_next = PH_HDR0;
          end else begin
            phase_next = PH_DATA;
          end
        end
        PH_EXT: begin
          if (count_done) begin
            if (frame_masked) begin
              phase_next = PH_KEY;
            end else if (rem_ext == '0) begin
              phase_next = PH_HDR0;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
        PH_KEY: begin
          if (count_done) begin
            phase_next = (remaining == '0) ? PH_HDR0 : PH_DATA;
          end
        end
        PH_DATA: begin
          if (remaining == LEN_ONE) begin
            phase_next = PH_HDR0;
          end
        end
        default: begin
          // The first header byte, and any phase code without a meaning.
          phase_next = PH_HDR1;
        end
      endcase
    end
  end

  // Datapath registers and the result of the current beat.
  always_comb begin
    ext_count_next = ext_count;
    frame_final_next = frame_final;
    frame_opcode_next = frame_opcode;
    msg_opcode_next = msg_opcode;
    frame_masked_next = frame_masked;
    remaining_next = remaining;
    mask_key_next = mask_key;
    mask_index_next = mask_index;
    emit = 1'b0;
    emit_last = 1'b0;
    emit_valid = 1'b0;
    emit_data = 8'd0;
    if (step) begin
      unique case (phase)
        PH_HDR1: begin
          frame_masked_next = rx_byte[7];
          if (len7 == LEN_EXT16) begin
            remaining_next = '0;
            ext_count_next = EXT16_BYTES;
          end else if (len7 == LEN_EXT64) begin
            remaining_next = '0;
            ext_count_next = EXT64_BYTES;
          end else begin
            remaining_next = {{(LENGTH_BITS-7){1'b0}}, len7};
            if (rx_byte[7]) begin
              ext_count_next = KEY_BYTES;
            end else if (len7 == 7'd0) begin
              emit = 1'b1;
              emit_last = 1'b1;
            end else begin
              mask_index_next = 2'd0;
            end
          end
        end
        PH_EXT: begin
          remaining_next = rem_ext;
          ext_count_next = ext_count - 4'd1;
          if (count_done) begin
            if (frame_masked) begin
              ext_count_next = KEY_BYTES;
            end else if (rem_ext == '0) begin
              emit = 1'b1;
              emit_last = 1'b1;
            end else begin
              mask_index_next = 2'd0;
            end
          end
        end
        PH_KEY: begin
          mask_key_next = {mask_key[23:0], rx_byte};
          ext_count_next = ext_count - 4'd1;
          if (count_done) begin
            if (remaining == '0) begin
              emit = 1'b1;
              emit_last = 1'b1;
            end else begin
              mask_index_next = 2'd0;
            end
          end
        end
        PH_DATA: begin
          mask_index_next = mask_index + 2'd1;
          remaining_next = remaining - LEN_ONE;
          emit = 1'b1;
          emit_valid = 1'b1;
          emit_last = (remaining == LEN_ONE);
          emit_data = frame_masked ? (rx_byte ^ key_byte) : rx_byte;
        end
        default: begin
          frame_final_next = rx_byte[7];
          frame_opcode_next = rx_byte[3:0];
          // Data opcodes open a new message; control opcodes leave it alone.
          if ((rx_byte[3:0] != OP_CONT) && !rx_byte[3]) begin
            msg_opcode_next = rx_byte[3:0];
          end
        end
      endcase
    end
  end

  // The closed flag changes on the last beat of a final close or pong frame.
  always_comb begin
    closed_flag_next = closed_flag;
    if (emit_last && frame_final) begin
      if (frame_opcode == OP_CLOSE) begin
        closed_flag_next = 1'b1;
      end else if (frame_opcode == OP_PONG) begin
        closed_flag_next = 1'b0;
      end
    end
  end

  // Result beat, tagged with the message opcode for continuation frames.
  always_comb begin
    res_valid = emit;
    res.payload_byte = emit_data;
    res.byte_valid = emit_valid;
    res.message_opcode = (frame_opcode == OP_CONT) ? msg_opcode : frame_opcode;
    res.frame_end = emit_last;
    res.message_end = emit_last && frame_final;
    res.peer_closed = closed_flag_next;
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HDR0;
      ext_count <= 4'd0;
      frame_final <= 1'b0;
      frame_opcode <= OP_CONT;
      msg_opcode <= OP_CONT;
      frame_masked <= 1'b0;
      remaining <= '0;
      mask_key <= 32'd0;
      mask_index <= 2'd0;
      closed_flag <= 1'b0;
    end else begin
      phase <= phase_next;
      ext_count <= ext_count_next;
      frame_final <= frame_final_next;
      frame_opcode <= frame_opcode_next;
      msg_opcode <= msg_opcode_next;
      frame_masked <= frame_masked_next;
      remaining <= remaining_next;
      mask_key <= mask_key_next;
      mask_index <= mask_index_next;
      closed_flag <= closed_flag_next;
    end
  end

endmodule

[rtl/websocket_frame_deframer.sv]
// A result beat is held in the output register from the cycle after the byte that causes it is taken.
// Throughput: one received byte per cycle while in_stall is low, as the parser updates on every byte taken.
// Bytes are still taken while a result waits, unless that result is stalled.
// Reset is synchronous and active high: the parser returns to the first header byte,
// all parse state and the closed flag are cleared, and the output register is emptied.
`timescale 1ns / 1ps

`include "websocket_frame_deframer_assert.svh"

module websocket_frame_deframer #(
  parameter int LENGTH_BITS = wsfd_pkg::LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] payload_byte,
  output logic       byte_valid,
  output logic [3:0] message_opcode,
  output logic       frame_end,
  output logic       message_end,
  output logic       peer_closed
);
  import wsfd_pkg::*;

  logic         in_accept;
  logic         res_valid;
  wsfd_result_t res;
  wsfd_result_t out_beat;

  // A new byte is taken unless a finished beat is held by the consumer.
  assign in_stall = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  wsfd_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .step     (in_accept),
    .rx_byte  (rx_byte),
    .res_valid(res_valid),
    .res      (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && res_valid) begin
      out_beat <= res;
    end
  end

  assign payload_byte = out_beat.payload_byte;
  assign byte_valid = out_beat.byte_valid;
  assign message_opcode = out_beat.message_opcode;
  assign frame_end = out_beat.frame_end;
  assign message_end = out_beat.message_end;
  assign peer_closed = out_beat.peer_closed;

  // Checks on the result beats.
  `WSFD_ASSERT_SAME(a_marker_ends_frame, clk, rst, out_valid && !byte_valid,
    frame_end && (payload_byte == 8'd0), "empty marker beat must end its frame")
  `WSFD_ASSERT_SAME(a_msg_end_in_frame_end, clk, rst, out_valid && message_end,
    frame_end, "message end without frame end")
  `WSFD_ASSERT_SAME(a_close_sets_flag, clk, rst,
    out_valid && message_end && (message_opcode == OP_CLOSE),
    peer_closed, "final close frame did not set the closed flag")
  `WSFD_ASSERT_SAME(a_pong_clears_flag, clk, rst,
    out_valid && message_end && (message_opcode == OP_PONG),
    !peer_closed, "final pong frame did not clear the closed flag")

endmodule
